// File: rtl/cpt_pkg.sv
package cpt_pkg;

  // default table geometry
  localparam int CPT_TABLE_DEPTH = 1024;
  localparam int CPT_KEY_WIDTH   = 16;

  // request actions
  typedef enum logic [2:0] {
    ACT_ADD        = 3'd0,
    ACT_SET_COUNT  = 3'd1,
    ACT_REMOVE     = 3'd2,
    ACT_FIND       = 3'd3,
    ACT_SET_REMOTE = 3'd4
  } action_t;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic clr_we;
    logic scan_run;
    logic wr_en;
    logic out_load;
  } cpt_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clear_last;
    logic scan_hit;
    logic scan_miss;
    logic act_known;
    logic need_write;
    logic out_free;
  } cpt_sts_t;

endpackage

// File: rtl/cpt_ctrl.sv
module cpt_ctrl
  import cpt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  cpt_sts_t sts,
  output cpt_cmd_t cmd
);

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    case (state)
      ST_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (!sts.act_known) begin
          state_next = ST_DONE;
        end else if (sts.scan_hit) begin
          state_next = sts.need_write ? ST_WRITE : ST_DONE;
        end else if (sts.scan_miss) begin
          state_next = ST_DONE;
        end
      end
      ST_WRITE: begin
        cmd.wr_en  = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

endmodule

// File: rtl/cpt_dpath.sv
module cpt_dpath
  import cpt_pkg::*;
#(
  parameter int TABLE_DEPTH = CPT_TABLE_DEPTH,
  parameter int KEY_WIDTH   = CPT_KEY_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  cpt_cmd_t    cmd,
  output cpt_sts_t    sts,
  input  logic [2:0]  action,
  input  logic [15:0] key_fd,
  input  logic [15:0] new_remote_fd,
  input  logic [31:0] ip_in,
  input  logic [15:0] port_in,
  input  logic [15:0] count_in,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        status,
  output logic [15:0] result_fd,
  output logic [15:0] found_client_fd,
  output logic [15:0] found_remote_fd,
  output logic [31:0] found_ip,
  output logic [15:0] found_port,
  output logic [15:0] found_count,
  output logic        hit_on_client
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic                 vld;
    logic [KEY_WIDTH-1:0] client;
    logic [KEY_WIDTH-1:0] remote;
    logic [31:0]          ip;
    logic [15:0]          port;
    logic [15:0]          count;
  } entry_t;

  entry_t mem [TABLE_DEPTH];

  // latched request
  action_t              act_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [KEY_WIDTH-1:0] remote_q;
  logic [31:0]          ip_q;
  logic [15:0]          port_q;
  logic [15:0]          count_q;

  // scan state
  logic [CW-1:0] cnt;
  logic          rd_vld;
  logic [AW-1:0] rd_idx;
  entry_t        rdata;
  logic          found;
  logic [AW-1:0] hit_idx;
  entry_t        hit_ent;

  logic [31:0]   key_wide;
  logic [31:0]   remote_wide;
  logic          in_range;
  logic          match;
  logic          re;
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [31:0]   key_ext;
  logic          is_find;

  assign key_wide    = {16'b0, key_fd};
  assign remote_wide = {16'b0, new_remote_fd};
  assign in_range    = cnt < CW'(TABLE_DEPTH);
  assign re          = cmd.scan_run && in_range;
  assign key_ext     = 32'(key_q);
  assign is_find     = act_q == ACT_FIND;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_q    <= action_t'(action);
      key_q    <= key_wide[KEY_WIDTH-1:0];
      remote_q <= remote_wide[KEY_WIDTH-1:0];
      ip_q     <= ip_in;
      port_q   <= port_in;
      count_q  <= count_in;
    end
  end

  // qualifying test for the entry just read
  always_comb begin
    case (act_q)
      ACT_ADD:        match = !rdata.vld;
      ACT_SET_COUNT,
      ACT_SET_REMOTE: match = rdata.vld && (rdata.client == key_q);
      ACT_REMOVE,
      ACT_FIND:       match = rdata.vld && ((rdata.client == key_q) ||
                                            (rdata.remote == key_q));
      default:        match = 1'b0;
    endcase
  end

  // status to the controller
  always_comb begin
    sts.clear_last = cnt == CW'(TABLE_DEPTH - 1);
    sts.scan_hit   = rd_vld && match;
    sts.scan_miss  = rd_vld && !match && (rd_idx == AW'(TABLE_DEPTH - 1));
    sts.need_write = !is_find;
    sts.out_free   = !rsp_valid || !rsp_stall;
    case (act_q)
      ACT_ADD, ACT_SET_COUNT, ACT_REMOVE, ACT_FIND, ACT_SET_REMOTE:
        sts.act_known = 1'b1;
      default:
        sts.act_known = 1'b0;
    endcase
  end

  // address counter, read pipeline and hit capture
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      rd_vld <= 1'b0;
      found  <= 1'b0;
    end else if (cmd.accept) begin
      cnt    <= '0;
      rd_vld <= 1'b0;
      found  <= 1'b0;
    end else if (cmd.clr_we) begin
      cnt    <= cnt + 1'b1;
      rd_vld <= 1'b0;
    end else if (cmd.scan_run) begin
      rd_vld <= in_range;
      if (in_range) begin
        cnt <= cnt + 1'b1;
      end
      if (sts.scan_hit) begin
        found <= 1'b1;
      end
    end else begin
      rd_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= cnt[AW-1:0];
    if (cmd.scan_run && sts.scan_hit && !found) begin
      hit_idx <= rd_idx;
      hit_ent <= rdata;
    end
  end

  // write data for the matched slot, or zero during the clearing pass
  always_comb begin
    wdata = hit_ent;
    case (act_q)
      ACT_ADD: begin
        wdata        = '0;
        wdata.vld    = 1'b1;
        wdata.client = key_q;
      end
      ACT_SET_COUNT: begin
        wdata.count = count_q;
      end
      ACT_REMOVE: begin
        wdata = '0;
      end
      ACT_SET_REMOTE: begin
        wdata.remote = remote_q;
        wdata.ip     = ip_q;
        wdata.port   = port_q;
      end
      default: begin
        wdata = hit_ent;
      end
    endcase
    if (cmd.clr_we) begin
      wdata = '0;
    end
  end

  assign we    = cmd.clr_we || cmd.wr_en;
  assign waddr = cmd.clr_we ? cnt[AW-1:0] : hit_idx;

  // entry memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[cnt[AW-1:0]];
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status          <= !found;
      result_fd       <= (found && act_q == ACT_ADD) ? key_ext[15:0] : 16'd0;
      found_client_fd <= '0;
      found_remote_fd <= '0;
      found_ip        <= '0;
      found_port      <= '0;
      found_count     <= '0;
      hit_on_client   <= 1'b0;
      if (found && is_find) begin
        found_client_fd <= 16'(32'(hit_ent.client));
        found_remote_fd <= 16'(32'(hit_ent.remote));
        found_ip        <= hit_ent.ip;
        found_port      <= hit_ent.port;
        found_count     <= hit_ent.count;
        hit_on_client   <= hit_ent.client == key_q;
      end
    end
  end

endmodule

// File: rtl/connection_pair_table.sv
// channel    | handshake               | payload
// -----------+-------------------------+-------------------------------------------
// request    | req_valid / req_stall   | action key_fd new_remote_fd ip_in port_in
//            |                         | count_in
// response   | rsp_valid / rsp_stall   | status result_fd found_* hit_on_client
//
// each request scans the entry memory from slot 0, one read a cycle on its
// read port, up to the first qualifying entry or the last slot; a hit for
// any action but a find adds a write to that slot, and an undefined action
// ends without a scan
// after reset a clearing pass writes zero to every slot, with req_stall
// held high
// a finished response sits in its register while the next request is taken;
// a held response only delays the following one
module connection_pair_table
  import cpt_pkg::*;
#(
  parameter int TABLE_DEPTH = CPT_TABLE_DEPTH,
  parameter int KEY_WIDTH   = CPT_KEY_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  action,
  input  logic [15:0] key_fd,
  input  logic [15:0] new_remote_fd,
  input  logic [31:0] ip_in,
  input  logic [15:0] port_in,
  input  logic [15:0] count_in,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        status,
  output logic [15:0] result_fd,
  output logic [15:0] found_client_fd,
  output logic [15:0] found_remote_fd,
  output logic [31:0] found_ip,
  output logic [15:0] found_port,
  output logic [15:0] found_count,
  output logic        hit_on_client
);

  cpt_cmd_t cmd;
  cpt_sts_t sts;

  // sequencer
  cpt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // entry memory, scan and response
  cpt_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .action          (action),
    .key_fd          (key_fd),
    .new_remote_fd   (new_remote_fd),
    .ip_in           (ip_in),
    .port_in         (port_in),
    .count_in        (count_in),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .status          (status),
    .result_fd       (result_fd),
    .found_client_fd (found_client_fd),
    .found_remote_fd (found_remote_fd),
    .found_ip        (found_ip),
    .found_port      (found_port),
    .found_count     (found_count),
    .hit_on_client   (hit_on_client)
  );

endmodule

// File: bench/connection_pair_table_tb.sv
module connection_pair_table_tb
  import cpt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH  = CPT_TABLE_DEPTH;
  localparam int QUIET_LIMIT  = 4 * (TABLE_DEPTH + 16);
  localparam int RANDOM_ITEMS = 560;
  localparam int LIVE_CEILING = 40;
  localparam int POOL_SIZE    = 12;
  localparam int MAX_REPORTS  = 50;
  localparam int MODE_SPAN    = 40;
  localparam int DRAIN_SPAN   = 100;
  localparam int TAIL_CYCLES  = 8;

  // action codes the block does not define
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  typedef struct packed {
    logic [2:0]  act;
    logic [15:0] key;
    logic [15:0] remote;
    logic [31:0] ip;
    logic [15:0] port;
    logic [15:0] count;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [15:0] result_fd;
    logic [15:0] client;
    logic [15:0] remote;
    logic [31:0] ip;
    logic [15:0] port;
    logic [15:0] count;
    logic        hit_on_client;
  } rsp_t;

  // mirror of the pair table plus the queue of responses still owed
  class pair_table_board;
    bit        used   [TABLE_DEPTH];
    bit [15:0] client [TABLE_DEPTH];
    bit [15:0] remote [TABLE_DEPTH];
    bit [31:0] ip     [TABLE_DEPTH];
    bit [15:0] port   [TABLE_DEPTH];
    bit [15:0] count  [TABLE_DEPTH];
    int        live;
    int        errors;
    rsp_t      expected_rsp[$];

    // lowest live slot owned by this client key
    function int first_client(bit [15:0] key);
      int i;
      for (i = 0; i < TABLE_DEPTH; i++)
        if (used[i] && client[i] == key) return i;
      return -1;
    endfunction

    // lowest live slot holding this key on either side
    function int first_either(bit [15:0] key);
      int i;
      for (i = 0; i < TABLE_DEPTH; i++)
        if (used[i] && (client[i] == key || remote[i] == key)) return i;
      return -1;
    endfunction

    // apply an accepted request and queue the response it owes
    function void note_request(req_t r);
      rsp_t e;
      int   slot;
      int   i;
      e        = '0;
      e.status = STATUS_MISS;
      slot     = -1;
      case (r.act)
        ACT_ADD: begin
          for (i = 0; i < TABLE_DEPTH && slot < 0; i++)
            if (!used[i]) slot = i;
          if (slot >= 0) begin
            used[slot]   = 1'b1;
            client[slot] = r.key;
            live++;
            e.status    = STATUS_OK;
            e.result_fd = r.key;
          end
        end
        ACT_SET_COUNT: begin
          slot = first_client(r.key);
          if (slot >= 0) begin
            count[slot] = r.count;
            e.status    = STATUS_OK;
          end
        end
        ACT_REMOVE: begin
          slot = first_either(r.key);
          if (slot >= 0) begin
            used[slot]   = 1'b0;
            client[slot] = '0;
            remote[slot] = '0;
            ip[slot]     = '0;
            port[slot]   = '0;
            count[slot]  = '0;
            live--;
            e.status = STATUS_OK;
          end
        end
        ACT_FIND: begin
          slot = first_either(r.key);
          if (slot >= 0) begin
            e.status        = STATUS_OK;
            e.client        = client[slot];
            e.remote        = remote[slot];
            e.ip            = ip[slot];
            e.port          = port[slot];
            e.count         = count[slot];
            e.hit_on_client = (client[slot] == r.key);
          end
        end
        ACT_SET_REMOTE: begin
          slot = first_client(r.key);
          if (slot >= 0) begin
            remote[slot] = r.remote;
            ip[slot]     = r.ip;
            port[slot]   = r.port;
            e.status     = STATUS_OK;
          end
        end
        default: begin
        end
      endcase
      expected_rsp.push_back(e);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    endtask

    // compare one response with the oldest one owed
    task check_response(rsp_t got);
      rsp_t want;
      if (expected_rsp.size() == 0) begin
        report("response with nothing pending", '0, '0);
      end else begin
        want = expected_rsp.pop_front();
        if (got.status !== want.status)
          report("status", 32'(got.status), 32'(want.status));
        if (got.result_fd !== want.result_fd)
          report("result_fd", 32'(got.result_fd), 32'(want.result_fd));
        if (got.client !== want.client)
          report("found_client_fd", 32'(got.client), 32'(want.client));
        if (got.remote !== want.remote)
          report("found_remote_fd", 32'(got.remote), 32'(want.remote));
        if (got.ip !== want.ip) report("found_ip", got.ip, want.ip);
        if (got.port !== want.port)
          report("found_port", 32'(got.port), 32'(want.port));
        if (got.count !== want.count)
          report("found_count", 32'(got.count), 32'(want.count));
        if (got.hit_on_client !== want.hit_on_client)
          report("hit_on_client", 32'(got.hit_on_client), 32'(want.hit_on_client));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  logic [2:0]  action;
  logic [15:0] key_fd;
  logic [15:0] new_remote_fd;
  logic [31:0] ip_in;
  logic [15:0] port_in;
  logic [15:0] count_in;
  logic        rsp_valid;
  logic        rsp_stall;
  logic        status;
  logic [15:0] result_fd;
  logic [15:0] found_client_fd;
  logic [15:0] found_remote_fd;
  logic [31:0] found_ip;
  logic [15:0] found_port;
  logic [15:0] found_count;
  logic        hit_on_client;

  pair_table_board board;
  logic [15:0]     key_pool [POOL_SIZE];
  bit              tx_steady;
  bit              rx_steady;

  connection_pair_table u_dut (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .action          (action),
    .key_fd          (key_fd),
    .new_remote_fd   (new_remote_fd),
    .ip_in           (ip_in),
    .port_in         (port_in),
    .count_in        (count_in),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .status          (status),
    .result_fd       (result_fd),
    .found_client_fd (found_client_fd),
    .found_remote_fd (found_remote_fd),
    .found_ip        (found_ip),
    .found_port      (found_port),
    .found_count     (found_count),
    .hit_on_client   (hit_on_client)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // drive one request after a random gap, none when tx_steady, and hold it until taken
  task automatic send_request(input req_t r);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid     <= 1'b1;
    action        <= r.act;
    key_fd        <= r.key;
    new_remote_fd <= r.remote;
    ip_in         <= r.ip;
    port_in       <= r.port;
    count_in      <= r.count;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    board.note_request(r);
  endtask

  task automatic put(input logic [2:0] act, input logic [15:0] key,
                     input logic [15:0] remote = '0, input logic [31:0] ip = '0,
                     input logic [15:0] port = '0, input logic [15:0] count = '0);
    req_t r;
    r = '{act, key, remote, ip, port, count};
    send_request(r);
  endtask

  // hold off the sender until every owed response is back
  task automatic await_drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (board.expected_rsp.size() != 0);
  endtask

  function automatic logic [15:0] pick_key();
    if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return 16'($urandom);
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   pick;
    r.key    = pick_key();
    r.remote = $urandom_range(0, 1) ? pick_key() : 16'($urandom);
    r.ip     = $urandom;
    r.port   = 16'($urandom);
    r.count  = 16'($urandom);
    pick     = $urandom_range(0, 99);
    if (pick < 22) r.act = ACT_ADD;
    else if (pick < 38) r.act = ACT_SET_COUNT;
    else if (pick < 56) r.act = ACT_REMOVE;
    else if (pick < 78) r.act = ACT_FIND;
    else if (pick < 95) r.act = ACT_SET_REMOTE;
    else r.act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    // keep the table shallow so most scans stay short
    if (r.act == ACT_ADD && board.live >= LIVE_CEILING) r.act = ACT_REMOVE;
    return r;
  endfunction

  // response side: random stall after each response unless rx_steady, check what is taken
  initial begin
    int rx_hold;
    rx_hold   = 0;
    rsp_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        board.check_response('{status, result_fd, found_client_fd, found_remote_fd,
                               found_ip, found_port, found_count, hit_on_client});
        rx_hold = rx_steady ? 0 : $urandom_range(0, 3);
      end else if (rx_hold > 0) begin
        rx_hold--;
      end
      rsp_stall <= (rx_hold > 0);
    end
  end

  // watchdog on stretches with no handshake on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
      else quiet++;
    end
    $display("connection_pair_table_tb failed");
    $finish;
  end

  initial begin
    int          sent;
    int          mode;
    logic [15:0] k;
    logic [15:0] nr;
    board = new;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    rst           <= 1'b1;
    req_valid     <= 1'b0;
    action        <= ACT_ADD;
    key_fd        <= '0;
    new_remote_fd <= '0;
    ip_in         <= '0;
    port_in       <= '0;
    count_in      <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // misses on an empty table
    put(ACT_FIND, 16'h0000);
    put(ACT_SET_COUNT, 16'h0000, '0, '0, '0, 16'hFFFF);
    put(ACT_SET_REMOTE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
    put(ACT_REMOVE, 16'hFFFF);
    // fill three slots with extreme and plain keys
    put(ACT_ADD, 16'h0000);
    put(ACT_ADD, 16'hFFFF);
    put(ACT_ADD, 16'h1234);
    // client key 0 with fresh remote 0: both sides match
    put(ACT_FIND, 16'h0000);
    put(ACT_REMOVE, 16'h0000);
    // fresh remote key 0 still matches a lookup of 0
    put(ACT_FIND, 16'h0000);
    put(ACT_SET_REMOTE, 16'hFFFF, 16'hABCD, 32'hFFFF_FFFF, 16'hFFFF);
    put(ACT_SET_COUNT, 16'hFFFF, '0, '0, '0, 16'hFFFF);
    put(ACT_FIND, 16'hABCD);
    put(ACT_FIND, 16'hFFFF);
    // duplicate key lands in the freed lower slot
    put(ACT_ADD, 16'h1234);
    put(ACT_SET_REMOTE, 16'h1234, 16'h1234, 32'h8000_0001, 16'h0001);
    put(ACT_FIND, 16'h1234);
    put(ACT_REMOVE, 16'hABCD);
    put(ACT_FIND, 16'hABCD);
    // undefined actions with every field but the second key at its top
    put(ACT_SPARE_LO, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    put(ACT_SPARE_HI, 16'h1234, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    put(ACT_SET_COUNT, 16'h1234, '0, '0, '0, 16'h0000);
    put(ACT_REMOVE, 16'h1234);
    put(ACT_REMOVE, 16'h1234);
    put(ACT_FIND, 16'h1234);
    await_drain();

    // random traffic, mostly connection lifecycles on a small key pool
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = 16'($urandom);
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % MODE_SPAN < 5) begin
        mode      = $urandom_range(0, 3);
        tx_steady = mode[0];
        rx_steady = mode[1];
        key_pool[$urandom_range(2, POOL_SIZE - 1)] = 16'($urandom);
      end
      if (sent % DRAIN_SPAN < 5 && sent > 0) await_drain();
      if ($urandom_range(0, 9) < 4) begin
        k  = pick_key();
        nr = pick_key();
        put(ACT_ADD, k, 16'($urandom), $urandom, 16'($urandom), 16'($urandom));
        put(ACT_SET_REMOTE, k, nr, $urandom, 16'($urandom), 16'($urandom));
        put(ACT_SET_COUNT, k, 16'($urandom), $urandom, 16'($urandom), 16'($urandom));
        put(ACT_FIND, $urandom_range(0, 1) ? k : nr);
        if (board.live >= LIVE_CEILING / 2 || $urandom_range(0, 1))
          put(ACT_REMOVE, $urandom_range(0, 1) ? k : nr);
        sent += 5;
      end else begin
        send_request(random_request());
        sent++;
      end
    end

    await_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("connection_pair_table_tb passed");
    end else begin
      $display("connection_pair_table_tb failed");
    end
    $finish;
  end

endmodule
